// ===== design/smbe_pkg.sv =====
package smbe_pkg;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  // One classified item as it sits in the queue between front and back.
  typedef struct packed {
    cmd_e       kind;
    logic [7:0] tx_byte;
    logic       device;
    logic       end_frame;
    logic       miso_level;
  } item_t;

  // One result item as held in the output register.
  typedef struct packed {
    logic       sck;
    logic       mosi;
    logic       cs_memory_n;
    logic       cs_reader_n;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       busy_res;
    logic       load_rejected;
  } res_t;

endpackage

// ===== design/smbe_front.sv =====
module smbe_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                cmd_i,
  input  logic [7:0]          tx_byte_i,
  input  logic                device_i,
  input  logic                end_frame_i,
  input  logic                miso_level_i,
  output logic                q_valid_o,
  output smbe_pkg::item_t     q_item_o,
  input  logic                q_pop_i
);
  import smbe_pkg::*;

  item_t      mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  item_t      item;
  logic       push, pop;

  assign in_ready_o = (count_q != 2'd2);
  assign q_valid_o  = (count_q != 2'd0);
  assign q_item_o   = mem_q[rd_ptr_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_pop_i && q_valid_o;

  // Classify the item and keep only the fields its kind uses.
  always_comb begin
    item = '0;
    if (cmd_i == CMD_TICK) begin
      item.kind       = CMD_TICK;
      item.miso_level = miso_level_i;
    end else begin
      item.kind      = CMD_LOAD;
      item.tx_byte   = tx_byte_i;
      item.device    = device_i;
      item.end_frame = end_frame_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

// ===== design/smbe_back.sv =====
module smbe_back #(
  parameter int WORD_BITS   = 8,
  parameter int NUM_SELECTS = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  smbe_pkg::item_t     q_item_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output smbe_pkg::res_t      res_o
);
  import smbe_pkg::*;

  localparam int CNT_W = $clog2(WORD_BITS + 1);
  localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(WORD_BITS - 1);

  logic [WORD_BITS-1:0]   tx_q, tx_d, rx_q, rx_d, tx_load;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic                   half_q, half_d;
  logic                   active_q, active_d;
  logic                   dev_q, dev_d;
  logic                   release_q, release_d;
  logic [NUM_SELECTS-1:0] sel_q, sel_d;
  logic                   clk_q, clk_d;
  logic                   data_q, data_d;
  logic                   rx_done, rejected;
  logic [7:0]             rx_low;
  logic                   cs1;
  logic                   out_valid_q;
  res_t                   res_q, res_d;

  // Words wider than a byte load with zero upper bits; narrower ones keep the low bits.
  generate
    if (WORD_BITS > 8) begin : g_wide
      assign tx_load = {{(WORD_BITS-8){1'b0}}, q_item_i.tx_byte};
      assign rx_low  = rx_d[7:0];
    end else if (WORD_BITS == 8) begin : g_byte
      assign tx_load = q_item_i.tx_byte;
      assign rx_low  = rx_d;
    end else begin : g_narrow
      assign tx_load = q_item_i.tx_byte[WORD_BITS-1:0];
      assign rx_low  = {{(8-WORD_BITS){1'b0}}, rx_d};
    end
    if (NUM_SELECTS > 1) begin : g_cs1
      assign cs1 = sel_d[1];
    end else begin : g_no_cs1
      assign cs1 = 1'b1;
    end
  endgenerate

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;
  assign q_pop_o     = q_valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    tx_d      = tx_q;
    rx_d      = rx_q;
    cnt_d     = cnt_q;
    half_d    = half_q;
    active_d  = active_q;
    dev_d     = dev_q;
    release_d = release_q;
    sel_d     = sel_q;
    clk_d     = clk_q;
    data_d    = data_q;
    rx_done   = 1'b0;
    rejected  = 1'b0;
    if (q_item_i.kind == CMD_LOAD) begin
      if (active_q) begin
        rejected = 1'b1;
      end else begin
        tx_d      = tx_load;
        rx_d      = '0;
        cnt_d     = '0;
        half_d    = 1'b0;
        active_d  = 1'b1;
        dev_d     = q_item_i.device;
        release_d = q_item_i.end_frame;
        for (int i = 0; i < NUM_SELECTS; i++) begin
          if (int'(q_item_i.device) == i) begin
            sel_d[i] = 1'b0;
          end
        end
      end
    end else if (active_q) begin
      if (!half_q) begin
        // Falling edge: present the next bit.
        clk_d  = 1'b0;
        data_d = tx_q[WORD_BITS-1];
        tx_d   = tx_q << 1;
        half_d = 1'b1;
      end else begin
        // Rising edge: sample the input line.
        clk_d  = 1'b1;
        rx_d   = {rx_q[WORD_BITS-2:0], q_item_i.miso_level};
        half_d = 1'b0;
        if (cnt_q == LAST_BIT) begin
          rx_done  = 1'b1;
          active_d = 1'b0;
          cnt_d    = '0;
          if (release_q) begin
            for (int i = 0; i < NUM_SELECTS; i++) begin
              if (int'(dev_q) == i) begin
                sel_d[i] = 1'b1;
              end
            end
          end
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
    end
  end

  always_comb begin
    res_d.sck           = clk_d;
    res_d.mosi          = data_d;
    res_d.cs_memory_n   = sel_d[0];
    res_d.cs_reader_n   = cs1;
    res_d.rx_byte       = rx_done ? rx_low : 8'd0;
    res_d.rx_valid      = rx_done;
    res_d.busy_res      = active_d;
    res_d.load_rejected = rejected;
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_q        <= '0;
      rx_q        <= '0;
      cnt_q       <= '0;
      half_q      <= 1'b0;
      active_q    <= 1'b0;
      dev_q       <= 1'b0;
      release_q   <= 1'b0;
      sel_q       <= '1;
      clk_q       <= 1'b1;
      data_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        tx_q        <= tx_d;
        rx_q        <= rx_d;
        cnt_q       <= cnt_d;
        half_q      <= half_d;
        active_q    <= active_d;
        dev_q       <= dev_d;
        release_q   <= release_d;
        sel_q       <= sel_d;
        clk_q       <= clk_d;
        data_q      <= data_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// ===== design/spi_master_byte_exchange.sv =====
// SPI master, mode 3 (clock idles high, MSB first), with active-low selects.
// Input channel (in_valid_i/in_ready_o): cmd_i = 0 loads tx_byte_i for the
// device named by device_i, end_frame_i releasing its select when the word
// completes; cmd_i = 1 is a half-bit tick, miso_level_i sampled on a rise.
// Output channel (out_valid_o/out_ready_i): exactly one result item per input
// item, showing pin levels after it, the received byte with rx_valid_o on the
// completing tick, busy_res_o, and load_rejected_o for a load while busy.
// The item is written into the two-entry queue at the accepting edge and is
// executed into the output register once the back end pops it, which waits
// while a stalled result still occupies the output register.
// Throughput is one item per cycle while the receiver does not stall, as the
// back end updates the shift registers and pin state for each item it pops.
// When the receiver stalls, the result stays in the output register and up
// to two more items collect in the queue before in_ready_o drops.
// Reset empties the queue and output register, raises the held select, clock
// and data levels behind the pins, and clears the shift registers and bit count.
module spi_master_byte_exchange #(
  parameter int WORD_BITS   = 8,
  parameter int NUM_SELECTS = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       cmd_i,
  input  logic [7:0] tx_byte_i,
  input  logic       device_i,
  input  logic       end_frame_i,
  input  logic       miso_level_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       sck_o,
  output logic       mosi_o,
  output logic       cs_memory_n_o,
  output logic       cs_reader_n_o,
  output logic [7:0] rx_byte_o,
  output logic       rx_valid_o,
  output logic       busy_res_o,
  output logic       load_rejected_o
);
  import smbe_pkg::*;

  logic  q_valid, q_pop;
  item_t q_item;
  res_t  res;

  smbe_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .tx_byte_i    (tx_byte_i),
    .device_i     (device_i),
    .end_frame_i  (end_frame_i),
    .miso_level_i (miso_level_i),
    .q_valid_o    (q_valid),
    .q_item_o     (q_item),
    .q_pop_i      (q_pop)
  );

  smbe_back #(
    .WORD_BITS   (WORD_BITS),
    .NUM_SELECTS (NUM_SELECTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign sck_o           = res.sck;
  assign mosi_o          = res.mosi;
  assign cs_memory_n_o   = res.cs_memory_n;
  assign cs_reader_n_o   = res.cs_reader_n;
  assign rx_byte_o       = res.rx_byte;
  assign rx_valid_o      = res.rx_valid;
  assign busy_res_o      = res.busy_res;
  assign load_rejected_o = res.load_rejected;

  // A completed word ends the exchange on a rising clock edge.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rx_valid_o |-> sck_o && !busy_res_o)
    else $error("word completed without a rising edge or while still busy");

  // A rejected load leaves the running exchange in place.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && load_rejected_o |-> busy_res_o && !rx_valid_o)
    else $error("rejected load reported outside an exchange");

  // A result is never dropped while the receiver stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(rx_byte_o))
    else $error("stalled result lost");

endmodule
